FILE: src/cds_pkg.sv
package cds_pkg;

  // Input item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_SHIFT = 1'b1;

  // Default date and year bounds
  localparam logic [4:0]  DEF_DAY   = 5'd1;
  localparam logic [3:0]  DEF_MONTH = 4'd1;
  localparam logic [15:0] DEF_YEAR  = 16'd2023;
  localparam logic [15:0] MAX_YEAR  = 16'd65535;
  localparam logic [15:0] MIN_YEAR  = 16'd1;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;
  localparam logic [4:0] DEC_LEN   = 5'd31;

  // Divisibility by 25: y * inverse(25) mod 2^16 stays at or below 65535 / 25
  localparam logic [15:0] INV25     = 16'd23593;
  localparam logic [15:0] DIV25_LIM = 16'd2621;

  // Width of the step counter: holds magnitudes up to 32768
  localparam int CNT_W = 17;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_FINISH
  } cds_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic step;
    logic emit;
  } cds_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic start_step;
    logic last;
  } cds_sts_t;

  // Leap year by the 4/100/400 rule, with the 25 test done by modular inverse
  function automatic logic is_leap(input logic [15:0] y);
    logic [15:0] prod;
    logic        div4;
    logic        div16;
    logic        div25;
    prod  = 16'(32'(y) * 32'(INV25));
    div4  = (y[1:0] == 2'd0);
    div16 = (y[3:0] == 4'd0);
    div25 = (prod <= DIV25_LIM);
    return div4 && (!div25 || div16);
  endfunction

  // Month length, 0 for a month out of range
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

FILE: src/cds_in_if.sv
interface cds_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [5:0]         day_in;
  logic [3:0]         month_in;
  logic [15:0]        year_in;
  logic signed [15:0] day_offset;

  modport source (output valid, kind, day_in, month_in, year_in, day_offset, input ready);
  modport sink   (input valid, kind, day_in, month_in, year_in, day_offset, output ready);
endinterface

FILE: src/cds_out_if.sv
interface cds_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  day_out;
  logic [3:0]  month_out;
  logic [15:0] year_out;
  logic        defaulted;

  modport source (output valid, day_out, month_out, year_out, defaulted, input ready);
  modport sink   (input valid, day_out, month_out, year_out, defaulted, output ready);
endinterface

FILE: src/calendar_date_day_stepper.sv
// Calendar date day stepper.
// Holds one Gregorian date. The input channel takes one word per item:
// kind 0 loads day_in/month_in/year_in (an invalid date falls back to
// 01/01/2023 and raises defaulted), kind 1 moves the date by the signed
// day_offset, one calendar day per cycle, saturating at 01/01/0001 and
// 31/12/65535. The output channel returns one word per item with the date
// held after the operation.
// A load or a zero shift goes from idle through the finish state into the output
// register; a nonzero shift first walks the step state one day per step. The
// cost is set by the single day-step unit, walked by a down counter.
// A new item is taken once the previous result has moved into the output
// register, so one result may wait on the output while the next item runs.
// If the receiver stalls with a word waiting, the next result holds in the
// finish state and input ready stays low until the word is taken.
// Reset clears the date to 01/01/2023, empties the output register and
// returns the controller to idle.
module calendar_date_day_stepper
  import cds_pkg::*;
(
  input logic      clk,
  input logic      rst,
  cds_in_if.sink   in_ch,
  cds_out_if.source out_ch
);

  cds_cmd_t cmd;
  cds_sts_t sts;

  cds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cds_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .kind       (in_ch.kind),
    .day_in     (in_ch.day_in),
    .month_in   (in_ch.month_in),
    .year_in    (in_ch.year_in),
    .day_offset (in_ch.day_offset),
    .day_out    (out_ch.day_out),
    .month_out  (out_ch.month_out),
    .year_out   (out_ch.year_out),
    .defaulted  (out_ch.defaulted)
  );

endmodule

FILE: src/cds_ctrl.sv
module cds_ctrl
  import cds_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  cds_sts_t sts,
  output cds_cmd_t cmd
);

  cds_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = sts.start_step ? ST_STEP : ST_FINISH;
        end
      end
      ST_STEP: begin
        cmd.step = 1'b1;
        if (sts.last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Move the result word into the output register once it is free
        if (!out_valid || out_ready) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output word valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: src/cds_dp.sv
module cds_dp
  import cds_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cds_cmd_t           cmd,
  output cds_sts_t           sts,
  input  logic               kind,
  input  logic [5:0]         day_in,
  input  logic [3:0]         month_in,
  input  logic [15:0]        year_in,
  input  logic signed [15:0] day_offset,
  output logic [4:0]         day_out,
  output logic [3:0]         month_out,
  output logic [15:0]        year_out,
  output logic               defaulted
);

  logic [4:0]       cur_day;
  logic [3:0]       cur_month;
  logic [15:0]      cur_year;
  logic             dflt;
  logic             back;
  logic [CNT_W-1:0] cnt;

  logic [CNT_W-1:0] mag;
  logic [4:0]       ld_len;
  logic             ld_ok;
  logic             cur_leap;
  logic [4:0]       cur_len;
  logic [3:0]       prev_month;
  logic [4:0]       prev_len;
  logic [4:0]       day_next;
  logic [3:0]       month_next;
  logic [15:0]      year_next;

  // Offset magnitude; the most negative offset gives 32768
  always_comb begin
    if (day_offset[15]) begin
      mag = CNT_W'(-{1'b1, day_offset});
    end else begin
      mag = CNT_W'({1'b0, day_offset});
    end
  end

  // Validate a load
  always_comb begin
    ld_len = month_len(month_in, is_leap(year_in));
    ld_ok  = (ld_len != 5'd0) && (day_in != 6'd0) && (day_in <= {1'b0, ld_len}) &&
             (year_in != 16'd0);
  end

  assign sts.start_step = (kind == KIND_SHIFT) && (mag != '0);
  assign sts.last       = (cnt == CNT_W'(1));

  // One calendar day forward or back, saturating at the year bounds
  always_comb begin
    cur_leap   = is_leap(cur_year);
    cur_len    = month_len(cur_month, cur_leap);
    prev_month = cur_month - 4'd1;
    prev_len   = month_len(prev_month, cur_leap);
    day_next   = cur_day;
    month_next = cur_month;
    year_next  = cur_year;
    if (!back) begin
      if (cur_day >= cur_len) begin
        if (cur_month >= MONTH_DEC) begin
          if (cur_year != MAX_YEAR) begin
            day_next   = DEF_DAY;
            month_next = MONTH_JAN;
            year_next  = cur_year + 16'd1;
          end
        end else begin
          day_next   = DEF_DAY;
          month_next = cur_month + 4'd1;
        end
      end else begin
        day_next = cur_day + 5'd1;
      end
    end else begin
      if (cur_day <= 5'd1) begin
        if (cur_month <= MONTH_JAN) begin
          if (cur_year > MIN_YEAR) begin
            day_next   = DEC_LEN;
            month_next = MONTH_DEC;
            year_next  = cur_year - 16'd1;
          end
        end else begin
          day_next   = prev_len;
          month_next = prev_month;
        end
      end else begin
        day_next = cur_day - 5'd1;
      end
    end
  end

  // Held date
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_day   <= DEF_DAY;
      cur_month <= DEF_MONTH;
      cur_year  <= DEF_YEAR;
    end else if (cmd.capture && kind == KIND_LOAD) begin
      if (ld_ok) begin
        cur_day   <= day_in[4:0];
        cur_month <= month_in;
        cur_year  <= year_in;
      end else begin
        cur_day   <= DEF_DAY;
        cur_month <= DEF_MONTH;
        cur_year  <= DEF_YEAR;
      end
    end else if (cmd.step) begin
      cur_day   <= day_next;
      cur_month <= month_next;
      cur_year  <= year_next;
    end
  end

  // Step counter, direction and fallback flag
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cnt  <= mag;
      back <= day_offset[15];
      dflt <= (kind == KIND_LOAD) && !ld_ok;
    end else if (cmd.step) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      day_out   <= cur_day;
      month_out <= cur_month;
      year_out  <= cur_year;
      defaulted <= dflt;
    end
  end

endmodule

FILE: src/cds_chk.sv
module cds_chk
  import cds_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  day_out,
  input logic [3:0]  month_out,
  input logic [15:0] year_out,
  input logic        defaulted
);

  // Hold a stalled output word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({day_out, month_out, year_out, defaulted}))
    else $error("output word changed while stalled");

  // Drop ready in the cycle after an accepted word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready stayed high after accept");

  // A delivered date is a real calendar date
  a_date_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> month_out >= MONTH_JAN && month_out <= MONTH_DEC && day_out != 5'd0 &&
                  year_out != 16'd0 && day_out <= month_len(month_out, is_leap(year_out)))
    else $error("output date out of range");

  // A fallback always reports the default date
  a_default_date: assert property (@(posedge clk) disable iff (rst)
    out_valid && defaulted |-> day_out == DEF_DAY && month_out == DEF_MONTH &&
                               year_out == DEF_YEAR)
    else $error("defaulted word without default date");

endmodule

bind calendar_date_day_stepper cds_chk u_cds_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .day_out   (out_ch.day_out),
  .month_out (out_ch.month_out),
  .year_out  (out_ch.year_out),
  .defaulted (out_ch.defaulted)
);
